[rtl/dau_pkg.sv]
package dau_pkg;

   localparam int DEF_MANTISSA_BITS    = 96;
   localparam int DEF_MAX_SCALE        = 28;
   localparam int DEF_EXTRA_DIV_DIGITS = 18;

   localparam int WIDE_BITS  = 256;
   localparam int LDIV_BITS  = 128;
   localparam int D10_CHUNK  = 16;
   localparam int D10_STEPS  = WIDE_BITS / D10_CHUNK;
   localparam int D10_RECIP  = 838861;
   localparam int D10_SHIFT  = 23;
   localparam logic [63:0] DIV_GUARD = 64'h1999999999999999;

   localparam int SC_BITS    = 8;
   localparam int DCNT_BITS  = 6;
   localparam int STEP_BITS  = $clog2(LDIV_BITS);

   localparam int OP_BITS       = 4;
   localparam int IN_SCALE_BITS = 5;
   localparam int OUT_MANT_BITS = 96;
   localparam int IN_DATA_BITS  = 216;
   localparam int OUT_DATA_BITS = 104;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_LESS  = 4'd4,
      OP_EQUAL = 4'd5,
      OP_TRUNC = 4'd6,
      OP_FLOOR = 4'd7,
      OP_CEIL  = 4'd8,
      OP_ROUND = 4'd9
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_DIV_ZERO  = 2'd1,
      ST_SCALE_NEG = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_PASS_A,
      DP_PASS_B,
      DP_ZERO,
      DP_ALIGN_SETUP,
      DP_ALIGN_MUL10,
      DP_COMBINE,
      DP_CMP_SET,
      DP_MUL_INIT,
      DP_MUL_STEP,
      DP_MUL_ADD,
      DP_MOVE_T,
      DP_DIV_INIT,
      DP_DIV_UP,
      DP_DIV_EXTRA,
      DP_LDIV_STEP,
      DP_D10_START,
      DP_D10_STEP,
      DP_D10_COMMIT,
      DP_DROP_SETUP,
      DP_DROP_COMMIT,
      DP_WHOLE_FIN,
      DP_ROUND_FIN,
      DP_MASK,
      DP_STATUS1,
      DP_STATUS2
   } dp_op_type;

   typedef enum logic [4:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_ALIGN,
      CS_MUL,
      CS_MUL_ADD,
      CS_MUL_MOVE,
      CS_DIV_UP,
      CS_LDIV,
      CS_FIT,
      CS_FIT_DIV,
      CS_FIT_CMT,
      CS_STRIP,
      CS_STRIP_DIV,
      CS_STRIP_CHK,
      CS_DROP,
      CS_DROP_DIV,
      CS_DROP_CMT,
      CS_OUT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               a_zero;
      logic               b_zero;
      logic               a_scale_zero;
      logic               places_ge;
      logic               dcnt_zero;
      logic               guard_hit;
      logic               sc_neg;
      logic               sc_pos;
      logic               fit_need;
      logic               rem_zero;
      logic               mul_last;
   } dp_stat_type;

endpackage

[rtl/decimal_arithmetic_unit.sv]
// channel  | ports                       | tdata (lsb up)                          | tuser
// req      | req_tvalid/tready/tdata/tuser | a_mant_low a_mant_high a_scale a_negative | operation
//          |                             | b_mant_low b_mant_high b_scale b_negative |
//          |                             | places, zero pad to 216                  |
// rsp      | rsp_tvalid/tready/tdata/tuser | r_mant_low r_mant_high r_scale          | status
//          |                             | r_negative compare_true                  |
// One beat at a time. The divide-by-ten unit, run once per decimal digit, does most of
// the work; divide adds a 128-bit restoring divider, multiply a nine-step 32x32
// partial-product loop.
// Synchronous active-high reset clears the controller and the result valid.
// A waiting result beat does not block the next request beat.
module decimal_arithmetic_unit import dau_pkg::*; #(
   parameter int MANTISSA_BITS    = DEF_MANTISSA_BITS,
   parameter int MAX_SCALE        = DEF_MAX_SCALE,
   parameter int EXTRA_DIV_DIGITS = DEF_EXTRA_DIV_DIGITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // a_mant_low, a_mant_high, a_scale, a_negative, b_mant_low, b_mant_high,
   // b_scale, b_negative, places
   input  logic [IN_DATA_BITS-1:0]  req_tdata,
   // operation
   input  logic [OP_BITS-1:0]       req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // r_mant_low, r_mant_high, r_scale, r_negative, compare_true
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]   rsp_tuser
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dau_datapath #(
      .MANTISSA_BITS    (MANTISSA_BITS),
      .MAX_SCALE        (MAX_SCALE),
      .EXTRA_DIV_DIGITS (EXTRA_DIV_DIGITS)
   ) u_datapath (
      .clock    (clock),
      .in_data  (req_tdata),
      .in_user  (req_tuser),
      .cmd      (cmd),
      .stat     (stat),
      .out_data (rsp_tdata),
      .out_user (rsp_tuser)
   );

   dau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[rtl/dau_datapath.sv]
module dau_datapath import dau_pkg::*; #(
   parameter int MANTISSA_BITS    = DEF_MANTISSA_BITS,
   parameter int MAX_SCALE        = DEF_MAX_SCALE,
   parameter int EXTRA_DIV_DIGITS = DEF_EXTRA_DIV_DIGITS
) (
   input  logic                     clock,
   input  logic [IN_DATA_BITS-1:0]  in_data,
   input  logic [OP_BITS-1:0]       in_user,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   output logic [OUT_DATA_BITS-1:0] out_data,
   output logic [STATUS_BITS-1:0]   out_user
);

   localparam int MUL_LIMBS = (MANTISSA_BITS + 31) / 32;
   localparam int LIMB_BITS = (MUL_LIMBS > 1) ? $clog2(MUL_LIMBS) : 1;
   localparam int PSH_BITS  = $clog2(2 * MUL_LIMBS - 1);
   localparam int REM_BITS  = MANTISSA_BITS + 1;
   localparam logic [LIMB_BITS-1:0] LIMB_LAST = LIMB_BITS'(MUL_LIMBS - 1);
   localparam logic [WIDE_BITS-1:0] MANT_MASK =
      {{(WIDE_BITS-MANTISSA_BITS){1'b0}}, {MANTISSA_BITS{1'b1}}};
   localparam logic signed [SC_BITS-1:0] MAX_SC = SC_BITS'(MAX_SCALE);
   localparam int D10_V_BITS = D10_CHUNK + 4;

   typedef logic signed [SC_BITS-1:0] sc_type;

   logic [WIDE_BITS-1:0]     x_ff, x_in, y_ff, y_in, t_ff, t_in;
   logic [63:0]              p_ff, p_in;
   logic [PSH_BITS-1:0]      psh_ff, psh_in;
   logic [LIMB_BITS-1:0]     mi_ff, mi_in, mj_ff, mj_in;
   logic [REM_BITS-1:0]      r_ff, r_in;
   logic [3:0]               rem_ff, rem_in, dig_ff, dig_in;
   logic                     frac_ff, frac_in;
   sc_type                   sc_ff, sc_in;
   logic                     neg_ff, neg_in, cmp_ff, cmp_in;
   status_type               status_ff, status_in;
   logic [DCNT_BITS-1:0]     dcnt_ff, dcnt_in;
   logic [OP_BITS-1:0]       op_ff, op_in;
   logic [IN_SCALE_BITS-1:0] as_ff, as_in, bs_ff, bs_in, pl_ff, pl_in;
   logic                     an_ff, an_in, bn_ff, bn_in, az_ff, az_in, bz_ff, bz_in;
   logic [OUT_DATA_BITS-1:0] od_ff, od_in;
   logic [STATUS_BITS-1:0]   ou_ff, ou_in;

   logic [WIDE_BITS-1:0]     a_load, b_load, p_shifted, x_inc;
   logic [D10_V_BITS-1:0]    d10_v, d10_back;
   logic [2*D10_V_BITS-1:0]  d10_prod;
   logic [D10_CHUNK-1:0]     d10_q;
   logic [REM_BITS-1:0]      ld_rc, ld_b;
   logic                     ld_ge, x_gt_max, x_lt_y, x_eq_y, a_lt_b_sc;
   logic [31:0]              limb_a, limb_b;
   sc_type                   sc_as, sc_bs, sc_negated;

   function automatic logic [WIDE_BITS-1:0] mul10(input logic [WIDE_BITS-1:0] v);
      mul10 = (v << 3) + (v << 1);
   endfunction

   assign a_load = {{(WIDE_BITS-96){1'b0}}, in_data[95:64], in_data[63:0]} & MANT_MASK;
   assign b_load = {{(WIDE_BITS-96){1'b0}}, in_data[197:166], in_data[165:102]} & MANT_MASK;

   assign sc_as      = sc_type'({{(SC_BITS-IN_SCALE_BITS){1'b0}}, as_ff});
   assign sc_bs      = sc_type'({{(SC_BITS-IN_SCALE_BITS){1'b0}}, bs_ff});
   assign sc_negated = -sc_ff;
   assign a_lt_b_sc  = as_ff < bs_ff;
   assign x_lt_y     = x_ff < y_ff;
   assign x_eq_y     = x_ff == y_ff;
   assign x_gt_max   = |(x_ff & ~MANT_MASK);
   assign x_inc      = x_ff + WIDE_BITS'(1);

   assign d10_v    = {rem_ff, y_ff[WIDE_BITS-1 -: D10_CHUNK]};
   assign d10_prod = (2*D10_V_BITS)'(d10_v) * (2*D10_V_BITS)'(D10_RECIP);
   assign d10_q    = d10_prod[D10_SHIFT +: D10_CHUNK];
   assign d10_back = d10_v - D10_V_BITS'(d10_q) * D10_V_BITS'(10);

   assign ld_rc = {r_ff[REM_BITS-2:0], x_ff[LDIV_BITS-1]};
   assign ld_b  = {1'b0, y_ff[MANTISSA_BITS-1:0]};
   assign ld_ge = ld_rc >= ld_b;

   assign limb_a    = x_ff[32*mi_ff +: 32];
   assign limb_b    = y_ff[32*mj_ff +: 32];
   assign p_shifted = {{(WIDE_BITS-64){1'b0}}, p_ff} << (32 * psh_ff);

   always_comb begin
      x_in = x_ff; y_in = y_ff; t_in = t_ff; p_in = p_ff; psh_in = psh_ff;
      mi_in = mi_ff; mj_in = mj_ff; r_in = r_ff; rem_in = rem_ff; dig_in = dig_ff;
      frac_in = frac_ff; sc_in = sc_ff; neg_in = neg_ff; cmp_in = cmp_ff;
      status_in = status_ff; dcnt_in = dcnt_ff; op_in = op_ff;
      as_in = as_ff; bs_in = bs_ff; pl_in = pl_ff;
      an_in = an_ff; bn_in = bn_ff; az_in = az_ff; bz_in = bz_ff;
      od_in = od_ff; ou_in = ou_ff;
      case (cmd.op)
         DP_LOAD: begin
            x_in = a_load;
            y_in = b_load;
            op_in = in_user;
            as_in = in_data[100:96];
            an_in = in_data[101];
            bs_in = in_data[202:198];
            bn_in = in_data[203] ^ (in_user == OP_SUB);
            pl_in = in_data[208:204];
            az_in = ~|a_load;
            bz_in = ~|b_load;
            cmp_in = 1'b0;
            status_in = ST_OK;
         end
         DP_PASS_A: begin
            sc_in = sc_as;
            neg_in = an_ff;
         end
         DP_PASS_B: begin
            x_in = y_ff;
            sc_in = sc_bs;
            neg_in = bn_ff;
         end
         DP_ZERO: begin
            x_in = '0;
            sc_in = '0;
            neg_in = 1'b0;
         end
         DP_ALIGN_SETUP: begin
            dcnt_in = a_lt_b_sc ? {1'b0, bs_ff - as_ff} : {1'b0, as_ff - bs_ff};
            sc_in = a_lt_b_sc ? sc_bs : sc_as;
         end
         DP_ALIGN_MUL10: begin
            if (a_lt_b_sc) begin
               x_in = mul10(x_ff);
            end else begin
               y_in = mul10(y_ff);
            end
            dcnt_in = dcnt_ff - DCNT_BITS'(1);
         end
         DP_COMBINE: begin
            if (an_ff == bn_ff) begin
               x_in = x_ff + y_ff;
               neg_in = an_ff;
            end else if (x_eq_y) begin
               x_in = '0;
               neg_in = 1'b0;
            end else if (x_lt_y) begin
               x_in = y_ff - x_ff;
               neg_in = bn_ff;
            end else begin
               x_in = x_ff - y_ff;
               neg_in = an_ff;
            end
         end
         DP_CMP_SET: begin
            if (az_ff && bz_ff) begin
               cmp_in = (op_ff == OP_EQUAL);
            end else if (an_ff != bn_ff) begin
               cmp_in = (op_ff == OP_LESS) && an_ff;
            end else if (op_ff == OP_EQUAL) begin
               cmp_in = x_eq_y;
            end else begin
               cmp_in = an_ff ? (!x_lt_y && !x_eq_y) : x_lt_y;
            end
            x_in = '0;
            sc_in = '0;
            neg_in = 1'b0;
         end
         DP_MUL_INIT: begin
            t_in = '0;
            p_in = '0;
            psh_in = '0;
            mi_in = '0;
            mj_in = '0;
            sc_in = sc_as + sc_bs;
            neg_in = an_ff ^ bn_ff;
         end
         DP_MUL_STEP: begin
            t_in = t_ff + p_shifted;
            p_in = 64'(limb_a) * 64'(limb_b);
            psh_in = PSH_BITS'(mi_ff) + PSH_BITS'(mj_ff);
            if (mj_ff == LIMB_LAST) begin
               mj_in = '0;
               mi_in = mi_ff + LIMB_BITS'(1);
            end else begin
               mj_in = mj_ff + LIMB_BITS'(1);
            end
         end
         DP_MUL_ADD: t_in = t_ff + p_shifted;
         DP_MOVE_T:  x_in = t_ff;
         DP_DIV_INIT: begin
            sc_in = sc_as - sc_bs;
            dcnt_in = DCNT_BITS'(EXTRA_DIV_DIGITS);
            neg_in = an_ff ^ bn_ff;
            r_in = '0;
         end
         DP_DIV_UP: begin
            x_in = mul10(x_ff);
            sc_in = sc_ff + sc_type'(1);
            dcnt_in = dcnt_ff - DCNT_BITS'(1);
         end
         DP_DIV_EXTRA: begin
            dcnt_in = (sc_negated > MAX_SC) ? MAX_SC[DCNT_BITS-1:0]
                                            : sc_negated[DCNT_BITS-1:0];
         end
         DP_LDIV_STEP: begin
            r_in = ld_ge ? ld_rc - ld_b : ld_rc;
            x_in = {{(WIDE_BITS-LDIV_BITS){1'b0}}, x_ff[LDIV_BITS-2:0], ld_ge};
         end
         DP_D10_START: begin
            y_in = x_ff;
            t_in = '0;
            rem_in = '0;
         end
         DP_D10_STEP: begin
            y_in = y_ff << D10_CHUNK;
            t_in = {t_ff[WIDE_BITS-D10_CHUNK-1:0], d10_q};
            rem_in = d10_back[3:0];
         end
         DP_D10_COMMIT: begin
            x_in = t_ff;
            sc_in = sc_ff - sc_type'(1);
         end
         DP_DROP_SETUP: begin
            dcnt_in = (op_ff == OP_ROUND) ? {1'b0, as_ff - pl_ff} : {1'b0, as_ff};
            frac_in = 1'b0;
            dig_in = '0;
         end
         DP_DROP_COMMIT: begin
            x_in = t_ff;
            dcnt_in = dcnt_ff - DCNT_BITS'(1);
            frac_in = frac_ff || (rem_ff != 4'd0);
            dig_in = rem_ff;
         end
         DP_WHOLE_FIN: begin
            sc_in = '0;
            neg_in = an_ff;
            if (frac_ff && (((op_ff == OP_FLOOR) && an_ff) || ((op_ff == OP_CEIL) && !an_ff)))
            begin
               x_in = x_inc & MANT_MASK;
            end
         end
         DP_ROUND_FIN: begin
            sc_in = sc_type'({{(SC_BITS-IN_SCALE_BITS){1'b0}}, pl_ff});
            neg_in = an_ff;
            if (dig_ff >= 4'd5) begin
               x_in = x_inc & MANT_MASK;
            end
         end
         DP_MASK: x_in = x_ff & MANT_MASK;
         DP_STATUS1: begin
            x_in = '0;
            sc_in = '0;
            neg_in = 1'b0;
            status_in = ST_DIV_ZERO;
         end
         DP_STATUS2: begin
            x_in = '0;
            sc_in = '0;
            neg_in = 1'b0;
            status_in = ST_SCALE_NEG;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         od_in = {cmp_ff, neg_ff, sc_ff[5:0], x_ff[OUT_MANT_BITS-1:0]};
         ou_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; t_ff <= t_in; p_ff <= p_in; psh_ff <= psh_in;
      mi_ff <= mi_in; mj_ff <= mj_in; r_ff <= r_in; rem_ff <= rem_in; dig_ff <= dig_in;
      frac_ff <= frac_in; sc_ff <= sc_in; neg_ff <= neg_in; cmp_ff <= cmp_in;
      status_ff <= status_in; dcnt_ff <= dcnt_in; op_ff <= op_in;
      as_ff <= as_in; bs_ff <= bs_in; pl_ff <= pl_in;
      an_ff <= an_in; bn_ff <= bn_in; az_ff <= az_in; bz_ff <= bz_in;
      od_ff <= od_in; ou_ff <= ou_in;
   end

   always_comb begin
      stat.op           = op_ff;
      stat.a_zero       = az_ff;
      stat.b_zero       = bz_ff;
      stat.a_scale_zero = (as_ff == '0);
      stat.places_ge    = pl_ff >= as_ff;
      stat.dcnt_zero    = (dcnt_ff == '0);
      stat.guard_hit    = (|x_ff[WIDE_BITS-1:LDIV_BITS]) || (x_ff[127:64] > DIV_GUARD);
      stat.sc_neg       = sc_ff[SC_BITS-1];
      stat.sc_pos       = !sc_ff[SC_BITS-1] && (sc_ff != '0);
      stat.fit_need     = ((op_ff == OP_MUL) && (sc_ff > MAX_SC)) ||
                          (x_gt_max && !sc_ff[SC_BITS-1] && (sc_ff != '0));
      stat.rem_zero     = (rem_ff == 4'd0);
      stat.mul_last     = (mi_ff == LIMB_LAST) && (mj_ff == LIMB_LAST);
   end

   assign out_data = od_ff;
   assign out_user = ou_ff;

endmodule

[rtl/dau_control.sv]
module dau_control import dau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam logic [STEP_BITS-1:0] D10_LAST  = STEP_BITS'(D10_STEPS - 1);
   localparam logic [STEP_BITS-1:0] LDIV_LAST = STEP_BITS'(LDIV_BITS - 1);

   ctl_state_type        state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      cmd.op       = DP_NOP;
      cmd.out_load = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_LOAD;
               state_in = CS_DISPATCH;
            end
         end
         CS_DISPATCH: begin
            phase_in = 1'b0;
            state_in = CS_OUT;
            if (stat.op inside {OP_ADD, OP_SUB}) begin
               if (stat.a_zero) begin
                  cmd.op = DP_PASS_B;
               end else if (stat.b_zero) begin
                  cmd.op = DP_PASS_A;
               end else begin
                  cmd.op = DP_ALIGN_SETUP;
                  state_in = CS_ALIGN;
               end
            end else if (stat.op inside {OP_LESS, OP_EQUAL}) begin
               cmd.op = DP_ALIGN_SETUP;
               state_in = CS_ALIGN;
            end else if (stat.op == OP_MUL) begin
               if (stat.a_zero || stat.b_zero) begin
                  cmd.op = DP_ZERO;
               end else begin
                  cmd.op = DP_MUL_INIT;
                  state_in = CS_MUL;
               end
            end else if (stat.op == OP_DIV) begin
               if (stat.b_zero) begin
                  cmd.op = DP_STATUS1;
               end else if (stat.a_zero) begin
                  cmd.op = DP_ZERO;
               end else begin
                  cmd.op = DP_DIV_INIT;
                  state_in = CS_DIV_UP;
               end
            end else if (stat.op inside {OP_TRUNC, OP_FLOOR, OP_CEIL}) begin
               if (stat.a_scale_zero || stat.a_zero) begin
                  cmd.op = DP_PASS_A;
               end else begin
                  cmd.op = DP_DROP_SETUP;
                  state_in = CS_DROP;
               end
            end else if (stat.op == OP_ROUND) begin
               if (stat.places_ge || stat.a_zero) begin
                  cmd.op = DP_PASS_A;
               end else begin
                  cmd.op = DP_DROP_SETUP;
                  state_in = CS_DROP;
               end
            end else begin
               cmd.op = DP_ZERO;
            end
         end
         CS_ALIGN: begin
            if (!stat.dcnt_zero) begin
               cmd.op = DP_ALIGN_MUL10;
            end else if (stat.op inside {OP_LESS, OP_EQUAL}) begin
               cmd.op = DP_CMP_SET;
               state_in = CS_OUT;
            end else begin
               cmd.op = DP_COMBINE;
               state_in = CS_FIT;
            end
         end
         CS_MUL: begin
            cmd.op = DP_MUL_STEP;
            if (stat.mul_last) begin
               state_in = CS_MUL_ADD;
            end
         end
         CS_MUL_ADD: begin
            cmd.op = DP_MUL_ADD;
            state_in = CS_MUL_MOVE;
         end
         CS_MUL_MOVE: begin
            cmd.op = DP_MOVE_T;
            state_in = CS_FIT;
         end
         CS_DIV_UP: begin
            if (!stat.dcnt_zero && !stat.guard_hit) begin
               cmd.op = DP_DIV_UP;
            end else if (stat.sc_neg && !phase_ff) begin
               cmd.op = DP_DIV_EXTRA;
               phase_in = 1'b1;
            end else if (stat.sc_neg) begin
               cmd.op = DP_STATUS2;
               state_in = CS_OUT;
            end else begin
               cnt_in = '0;
               state_in = CS_LDIV;
            end
         end
         CS_LDIV: begin
            cmd.op = DP_LDIV_STEP;
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (cnt_ff == LDIV_LAST) begin
               state_in = CS_FIT;
            end
         end
         CS_FIT: begin
            cnt_in = '0;
            if (stat.fit_need) begin
               cmd.op = DP_D10_START;
               state_in = CS_FIT_DIV;
            end else begin
               cmd.op = DP_MASK;
               state_in = CS_STRIP;
            end
         end
         CS_FIT_DIV: begin
            cmd.op = DP_D10_STEP;
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (cnt_ff == D10_LAST) begin
               state_in = CS_FIT_CMT;
            end
         end
         CS_FIT_CMT: begin
            cmd.op = DP_D10_COMMIT;
            state_in = CS_FIT;
         end
         CS_STRIP: begin
            cnt_in = '0;
            if (stat.sc_pos) begin
               cmd.op = DP_D10_START;
               state_in = CS_STRIP_DIV;
            end else begin
               state_in = CS_OUT;
            end
         end
         CS_STRIP_DIV: begin
            cmd.op = DP_D10_STEP;
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (cnt_ff == D10_LAST) begin
               state_in = CS_STRIP_CHK;
            end
         end
         CS_STRIP_CHK: begin
            if (stat.rem_zero) begin
               cmd.op = DP_D10_COMMIT;
               state_in = CS_STRIP;
            end else begin
               state_in = CS_OUT;
            end
         end
         CS_DROP: begin
            cnt_in = '0;
            if (!stat.dcnt_zero) begin
               cmd.op = DP_D10_START;
               state_in = CS_DROP_DIV;
            end else begin
               cmd.op = (stat.op == OP_ROUND) ? DP_ROUND_FIN : DP_WHOLE_FIN;
               state_in = CS_OUT;
            end
         end
         CS_DROP_DIV: begin
            cmd.op = DP_D10_STEP;
            cnt_in = cnt_ff + STEP_BITS'(1);
            if (cnt_ff == D10_LAST) begin
               state_in = CS_DROP_CMT;
            end
         end
         CS_DROP_CMT: begin
            cmd.op = DP_DROP_COMMIT;
            state_in = CS_DROP;
         end
         CS_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == CS_DISPATCH))
      else $error("accepted beat not dispatched");
   a_d10_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_FIT_DIV || state_ff == CS_STRIP_DIV || state_ff == CS_DROP_DIV)
      |-> (cnt_ff <= D10_LAST))
      else $error("divide-by-ten step count overrun");
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !cmd.out_load) |=> !rsp_valid_ff)
      else $error("result beat repeated");
`endif

endmodule

[sim/tb_decimal_arithmetic_unit.sv]
module tb_decimal_arithmetic_unit;
   import dau_pkg::*;

   typedef struct {
      logic [3:0]  op;
      logic [95:0] am;
      logic [4:0]  asc;
      logic        aneg;
      logic [95:0] bm;
      logic [4:0]  bsc;
      logic        bneg;
      logic [4:0]  places;
      bit          drain_first;
   } dec_req_t;

   typedef struct {
      logic [95:0] mant;
      logic [5:0]  scale;
      logic        neg;
      logic        cmp;
      logic [1:0]  st;
   } dec_res_t;

   localparam logic [255:0] MAG_MAX = {160'b0, {96{1'b1}}};
   localparam int           STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [IN_DATA_BITS-1:0] req_tdata;
   logic [OP_BITS-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [OUT_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0] rsp_tuser;

   dec_req_t pending_reqs[$];
   dec_res_t results_due[$];
   int       errors;
   int       idle_cycles;
   bit       req_taken;
   bit       stimulus_done;
   int       req_gap;
   int       rsp_stall;
   bit       req_calm;
   bit       rsp_calm;

   decimal_arithmetic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- decimal predictor ----
   function automatic logic [255:0] times_ten_pow(logic [255:0] v, int n);
      for (int i = 0; i < n; i++) v = v * 10;
      return v;
   endfunction

   function automatic void fit_trim(inout logic [255:0] m, inout int sc, input bit cap);
      while ((cap && sc > DEF_MAX_SCALE) || (m > MAG_MAX && sc > 0)) begin
         m = m / 10;
         sc--;
      end
      m = m & MAG_MAX;
   endfunction

   function automatic void strip_trailing(inout logic [255:0] m, inout int sc);
      while (sc > 0 && (m % 10) == 0) begin
         m = m / 10;
         sc--;
      end
   endfunction

   function automatic bit guard_hit(logic [255:0] n);
      return (n[255:128] != 0) || (n[127:64] > DIV_GUARD);
   endfunction

   function automatic dec_res_t decimal_outcome(dec_req_t q);
      dec_res_t     r;
      logic [255:0] am, bm, l, rr, m;
      int           sc, ts, lim, drop;
      logic         neg, bneg, frac;
      logic [3:0]   dig;
      am = {160'b0, q.am};
      bm = {160'b0, q.bm};
      bneg = q.bneg;
      r = '{mant: '0, scale: '0, neg: 1'b0, cmp: 1'b0, st: ST_OK};
      m = '0;
      sc = 0;
      neg = 1'b0;
      case (q.op)
         OP_ADD, OP_SUB: begin
            if (q.op == OP_SUB) bneg = ~bneg;
            if (am == 0) begin
               m = bm; sc = q.bsc; neg = bneg;
            end else if (bm == 0) begin
               m = am; sc = q.asc; neg = q.aneg;
            end else begin
               l = (q.asc < q.bsc) ? times_ten_pow(am, q.bsc - q.asc) : am;
               rr = (q.bsc < q.asc) ? times_ten_pow(bm, q.asc - q.bsc) : bm;
               sc = (q.asc > q.bsc) ? q.asc : q.bsc;
               if (q.aneg == bneg) begin
                  m = l + rr; neg = q.aneg;
               end else if (l > rr) begin
                  m = l - rr; neg = q.aneg;
               end else if (l < rr) begin
                  m = rr - l; neg = bneg;
               end else begin
                  m = '0; neg = 1'b0;
               end
               fit_trim(m, sc, 1'b0);
               strip_trailing(m, sc);
            end
         end
         OP_MUL: begin
            if (am != 0 && bm != 0) begin
               m = am * bm;
               sc = q.asc + q.bsc;
               neg = q.aneg != q.bneg;
               fit_trim(m, sc, 1'b1);
               strip_trailing(m, sc);
            end
         end
         OP_DIV: begin
            if (bm == 0) r.st = ST_DIV_ZERO;
            else if (am != 0) begin
               l = am;
               ts = int'(q.asc) - int'(q.bsc);
               for (int i = 0; i < DEF_EXTRA_DIV_DIGITS; i++) begin
                  if (guard_hit(l)) break;
                  l = l * 10;
                  ts++;
               end
               if (ts < 0) begin
                  lim = -ts;
                  for (int i = 0; i < lim && i < DEF_MAX_SCALE; i++) begin
                     if (guard_hit(l)) break;
                     l = l * 10;
                     ts++;
                  end
               end
               if (ts < 0) r.st = ST_SCALE_NEG;
               else begin
                  m = l / bm;
                  sc = ts;
                  neg = q.aneg != q.bneg;
                  fit_trim(m, sc, 1'b0);
                  strip_trailing(m, sc);
               end
            end
         end
         OP_LESS, OP_EQUAL: begin
            l = (q.asc < q.bsc) ? times_ten_pow(am, q.bsc - q.asc) : am;
            rr = (q.bsc < q.asc) ? times_ten_pow(bm, q.asc - q.bsc) : bm;
            if (am == 0 && bm == 0) r.cmp = (q.op == OP_EQUAL);
            else if (q.aneg != q.bneg) r.cmp = (q.op == OP_LESS) ? q.aneg : 1'b0;
            else if (q.op == OP_EQUAL) r.cmp = (l == rr);
            else r.cmp = q.aneg ? (l > rr) : (l < rr);
         end
         OP_TRUNC, OP_FLOOR, OP_CEIL, OP_ROUND: begin
            m = am; sc = q.asc; neg = q.aneg;
            drop = (q.op == OP_ROUND) ? int'(q.asc) - int'(q.places) : int'(q.asc);
            if (drop > 0 && am != 0) begin
               frac = 1'b0;
               dig = '0;
               for (int i = 0; i < drop; i++) begin
                  dig = 4'(m % 10);
                  if (dig != 0) frac = 1'b1;
                  m = m / 10;
               end
               sc = (q.op == OP_ROUND) ? int'(q.places) : 0;
               if ((q.op == OP_ROUND && dig >= 5) ||
                   (frac && ((q.op == OP_FLOOR && q.aneg) || (q.op == OP_CEIL && !q.aneg))))
                  m = (m + 1) & MAG_MAX;
            end
         end
         default: ;
      endcase
      r.mant = m[95:0];
      r.scale = 6'(sc);
      r.neg = neg;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // ---- stimulus helpers ----
   function automatic logic [95:0] rand_mant();
      logic [95:0]  v;
      logic [255:0] p;
      v = {$urandom, $urandom, $urandom};
      p = times_ten_pow(256'd1, $urandom_range(0, 28));
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return 96'($urandom_range(1, 1000));
         3: return {32'b0, v[63:0]};
         4: return '1;
         5: return p[95:0];
         6: return 96'($urandom_range(1, 99)) * 96'(10 ** $urandom_range(0, 9));
         default: return v;
      endcase
   endfunction

   function automatic logic [4:0] rand_scale();
      return ($urandom_range(0, 15) == 0) ? 5'($urandom_range(29, 31))
                                          : 5'($urandom_range(0, 28));
   endfunction

   function automatic dec_req_t rand_req();
      dec_req_t q;
      q.op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      q.am = rand_mant();
      q.bm = rand_mant();
      q.asc = rand_scale();
      q.bsc = ($urandom_range(0, 3) == 0) ? q.asc : rand_scale();
      q.aneg = 1'($urandom_range(0, 1));
      q.bneg = 1'($urandom_range(0, 1));
      q.places = 5'($urandom);
      q.drain_first = 1'b0;
      return q;
   endfunction

   function automatic dec_req_t mk(logic [3:0] op, logic [95:0] am, logic [4:0] asc,
                                   logic aneg, logic [95:0] bm, logic [4:0] bsc,
                                   logic bneg, logic [4:0] places);
      dec_req_t q;
      q = '{op, am, asc, aneg, bm, bsc, bneg, places, 1'b0};
      return q;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   task automatic queue_req(dec_req_t q);
      pending_reqs.insert(pending_reqs.size(), q);
   endtask

   initial begin
      dec_req_t q;
      errors = 0;
      stimulus_done = 0;
      reset = 1'b1;
      queue_req(mk(OP_ADD, '1, 0, 0, '1, 0, 0, 0));
      queue_req(mk(OP_ADD, 96'd5, 2, 1, 96'd5, 2, 0, 0));
      queue_req(mk(OP_ADD, 96'd3, 1, 1, 96'd250, 3, 0, 0));
      queue_req(mk(OP_SUB, '0, 0, 0, 96'd77, 31, 0, 0));
      queue_req(mk(OP_SUB, '1, 28, 0, '0, 5, 1, 0));
      queue_req(mk(OP_SUB, '1, 0, 0, '1, 28, 1, 0));
      queue_req(mk(OP_MUL, '1, 28, 1, '1, 28, 0, 0));
      queue_req(mk(OP_MUL, '1, 0, 0, '1, 0, 0, 0));
      queue_req(mk(OP_MUL, '0, 3, 1, 96'd9, 2, 0, 0));
      queue_req(mk(OP_DIV, 96'd1, 0, 0, 96'd3, 0, 1, 0));
      queue_req(mk(OP_DIV, 96'd7, 4, 0, '0, 0, 0, 0));
      queue_req(mk(OP_DIV, '1, 0, 0, 96'd7, 28, 0, 0));
      queue_req(mk(OP_DIV, '1, 28, 1, 96'd1, 0, 0, 0));
      queue_req(mk(OP_DIV, '0, 0, 1, 96'd4, 0, 0, 0));
      queue_req(mk(OP_LESS, '0, 0, 1, '0, 3, 0, 0));
      queue_req(mk(OP_LESS, 96'd10, 1, 1, 96'd1, 0, 1, 0));
      queue_req(mk(OP_EQUAL, '0, 0, 1, '0, 5, 0, 0));
      queue_req(mk(OP_EQUAL, 96'd10, 1, 0, 96'd1, 0, 0, 0));
      queue_req(mk(OP_TRUNC, 96'd1999, 3, 1, '0, 0, 0, 0));
      queue_req(mk(OP_FLOOR, 96'd1500, 3, 1, '0, 0, 0, 0));
      queue_req(mk(OP_CEIL, '1, 1, 0, '0, 0, 0, 0));
      queue_req(mk(OP_CEIL, 96'd42, 0, 0, '0, 0, 0, 0));
      queue_req(mk(OP_ROUND, '1, 28, 0, '0, 0, 0, 27));
      queue_req(mk(OP_ROUND, 96'd12345, 4, 1, '0, 0, 0, 31));
      queue_req(mk(4'd15, '1, 31, 1, '1, 31, 1, '1));
      for (int i = 0; i < 1350; i++) begin
         q = rand_req();
         q.drain_first = (i == 300 || i == 900);
         queue_req(q);
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_reqs.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
      stimulus_done = 1;
      repeat (1200) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // driver
   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      req_taken = 0;
      req_gap = 0;
      rsp_stall = 0;
      req_calm = 0;
      rsp_calm = 0;
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         req_taken = 0;
         if ($urandom_range(0, 199) == 0) req_calm = ~req_calm;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first && results_due.size() != 0)) begin
            req_tdata <= {7'b0, pending_reqs[0].places,
                          pending_reqs[0].bneg, pending_reqs[0].bsc, pending_reqs[0].bm,
                          pending_reqs[0].aneg, pending_reqs[0].asc, pending_reqs[0].am};
            req_tuser <= pending_reqs[0].op;
            req_tvalid <= 1'b1;
            void'(pending_reqs.pop_front());
            req_gap = req_calm ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if ($urandom_range(0, 199) == 0) rsp_calm = ~rsp_calm;
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_calm) rsp_stall = pick_gap();
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      dec_req_t q;
      dec_res_t want;
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            req_taken = 1;
            idle_cycles = 0;
            q.am = req_tdata[95:0];
            q.asc = req_tdata[100:96];
            q.aneg = req_tdata[101];
            q.bm = req_tdata[197:102];
            q.bsc = req_tdata[202:198];
            q.bneg = req_tdata[203];
            q.places = req_tdata[208:204];
            q.op = req_tuser;
            q.drain_first = 1'b0;
            results_due.insert(results_due.size(), decimal_outcome(q));
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            if (results_due.size() == 0) begin
               $display("unexpected result beat at %0t", $time);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[95:0] !== want.mant)
                  report_mismatch("magnitude", rsp_tdata[95:0], want.mant);
               if (rsp_tdata[101:96] !== want.scale)
                  report_mismatch("scale", 96'(rsp_tdata[101:96]), 96'(want.scale));
               if (rsp_tdata[102] !== want.neg)
                  report_mismatch("sign", 96'(rsp_tdata[102]), 96'(want.neg));
               if (rsp_tdata[103] !== want.cmp)
                  report_mismatch("compare", 96'(rsp_tdata[103]), 96'(want.cmp));
               if (rsp_tuser !== want.st)
                  report_mismatch("status", 96'(rsp_tuser), 96'(want.st));
            end
         end
         if (!stimulus_done && idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end else begin
         idle_cycles = 0;
      end
   end

endmodule
